/* design/srt_pkg.sv */
// Shared types and codes for the sorted record table.
`default_nettype none

package srt_pkg;

    localparam int KEY_BITS = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_DUMP   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_RD,
        S_DEL_CMP,
        S_DMP_RD,
        S_DMP_OUT,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

/* design/sorted_record_table.sv */
// Sorted record table: records kept in ascending signed key order in a RAM.
`default_nettype none

// Holds up to CAPACITY records (signed 32-bit key plus payload) in ascending
// key order in a single-port-write, registered-read RAM, walked by a small
// sequencer with a less-than and an equality key compare. One item is handled
// at a time; in_ready is high only when the sequencer is idle. Each RAM step
// is a read state, then a compare-and-write state. Insert walks down from the
// top of the table, moving each larger-or-equal record up one slot. Delete
// walks the whole table, finding the first match and moving later records
// down. Dump reads and emits the records one at a time in order, waiting
// while the output is stalled. Full and empty cases go straight to the
// response state; an unused code is taken while idle and gives no item.
// RAM contents need no clearing after reset; only entries below the fill
// count are read for results.
module sorted_record_table
    import srt_pkg::*;
#(
    parameter int CAPACITY     = 32,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 func,
    input  wire logic signed [KEY_BITS-1:0] key,
    input  wire logic [PAYLOAD_BITS-1:0]    payload,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      status,
    output logic signed [KEY_BITS-1:0]      rec_key,
    output logic [PAYLOAD_BITS-1:0]         rec_payload,
    output logic                            last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // record RAM
    logic signed [KEY_BITS-1:0] key_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0]    pay_mem [CAPACITY];
    logic signed [KEY_BITS-1:0] rd_key_reg;
    logic [PAYLOAD_BITS-1:0]    rd_pay_reg;

    logic                       mem_we;
    logic [IW-1:0]              waddr;
    logic [IW-1:0]              raddr;
    logic signed [KEY_BITS-1:0] wkey;
    logic [PAYLOAD_BITS-1:0]    wpay;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic                       found_reg, found_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic [PAYLOAD_BITS-1:0]    pay_reg, pay_next;
    status_t                    resp_reg, resp_next;

    logic                       out_valid_reg;
    logic [1:0]                 status_reg;
    logic signed [KEY_BITS-1:0] rec_key_reg;
    logic [PAYLOAD_BITS-1:0]    rec_pay_reg;
    logic                       last_reg;

    logic                       emit;
    status_t                    emit_status;
    logic signed [KEY_BITS-1:0] emit_key;
    logic [PAYLOAD_BITS-1:0]    emit_pay;
    logic                       emit_last;
    logic                       slot_free;
    logic                       at_end;
    logic                       match;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[waddr] <= wkey;
            pay_mem[waddr] <= wpay;
        end
        rd_key_reg <= key_mem[raddr];
        rd_pay_reg <= pay_mem[raddr];
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign at_end    = (idx_reg == count_reg - CW'(1));
    assign match     = (rd_key_reg == key_reg);
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        resp_next   = resp_reg;
        mem_we      = 1'b0;
        waddr       = idx_reg[IW-1:0];
        raddr       = idx_reg[IW-1:0];
        wkey        = key_reg;
        wpay        = pay_reg;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_key    = '0;
        emit_pay    = '0;
        emit_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next   = key;
                    pay_next   = payload;
                    idx_next   = '0;
                    found_next = 1'b0;
                    case (func)
                        FUNC_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                resp_next  = ST_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                resp_next  = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_DEL_RD;
                            end
                        end
                        FUNC_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                resp_next  = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_DMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_RD:
            begin
                raddr = idx_reg[IW-1:0] - IW'(1);
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    resp_next  = ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (rd_key_reg < key_reg)
                begin
                    count_next = count_reg + CW'(1);
                    resp_next  = ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    // move the larger-or-equal record up one slot
                    wkey       = rd_key_reg;
                    wpay       = rd_pay_reg;
                    idx_next   = idx_reg - CW'(1);
                    state_next = S_INS_RD;
                end
            end

            S_DEL_RD:
            begin
                state_next = S_DEL_CMP;
            end

            S_DEL_CMP:
            begin
                if (found_reg)
                begin
                    // close the gap left by the removed record
                    mem_we = 1'b1;
                    waddr  = idx_reg[IW-1:0] - IW'(1);
                    wkey   = rd_key_reg;
                    wpay   = rd_pay_reg;
                end
                found_next = found_reg || match;
                if (at_end)
                begin
                    if (found_reg || match)
                    begin
                        count_next = count_reg - CW'(1);
                        resp_next  = ST_OK;
                    end
                    else
                    begin
                        resp_next = ST_NOTFOUND;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_DEL_RD;
                end
            end

            S_DMP_RD:
            begin
                state_next = S_DMP_OUT;
            end

            S_DMP_OUT:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_key  = rd_key_reg;
                    emit_pay  = rd_pay_reg;
                    emit_last = at_end;
                    if (at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_DMP_RD;
                    end
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    emit_status = resp_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        pay_reg  <= pay_next;
        resp_reg <= resp_next;
        if (emit)
        begin
            status_reg  <= emit_status;
            rec_key_reg <= emit_key;
            rec_pay_reg <= emit_pay;
            last_reg    <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign rec_key     = rec_key_reg;
    assign rec_payload = rec_pay_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire
